FILE: hdl/chfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chfm_pkg
// Shared types, constants and the arctangent table for the compass heading.
// ----------------------------------------------------------------------------
package chfm_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int OFFSET_W  = 13;
    localparam int CENTRE_W  = 18;
    localparam int SPAN_W    = 17;
    localparam int PROD_W    = 35;
    localparam int CORD_W    = 58;
    localparam int PRESHIFT  = 20;
    localparam int ANGLE_W   = 16;
    localparam int PHI_W     = 18;
    localparam int HEADING_W = 9;
    localparam int CFG_IDX_W = 3;
    localparam int ANG_FRAC  = 8;
    localparam int MAX_STAGES = 24;

    localparam logic [CFG_IDX_W-1:0] REG_X_MAX  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_MIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_MAX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_MIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd4;

    localparam logic signed [PHI_W-1:0] PHI_0   = 18'sd0;
    localparam logic signed [PHI_W-1:0] PHI_90  = 18'sd23040;
    localparam logic signed [PHI_W-1:0] PHI_180 = 18'sd46080;
    localparam logic signed [PHI_W-1:0] PHI_270 = 18'sd69120;

    typedef struct packed {
        logic signed [PROD_W-1:0] wx;
        logic signed [PROD_W-1:0] wy;
        logic                     special;
        logic signed [PHI_W-1:0]  base;
    } t_work;

    function automatic logic signed [ANGLE_W-1:0] atan_tab(input int idx);
        logic signed [ANGLE_W-1:0] v;
        case (idx)
            0:  v = 16'sd11520;
            1:  v = 16'sd6801;
            2:  v = 16'sd3593;
            3:  v = 16'sd1824;
            4:  v = 16'sd916;
            5:  v = 16'sd458;
            6:  v = 16'sd229;
            7:  v = 16'sd115;
            8:  v = 16'sd57;
            9:  v = 16'sd29;
            10: v = 16'sd14;
            11: v = 16'sd7;
            12: v = 16'sd4;
            13: v = 16'sd2;
            14: v = 16'sd1;
            default: v = 16'sd0;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/compass_heading_from_magnetometer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compass_heading_from_magnetometer_top
// Hard-iron corrected compass heading from raw x/y magnetometer samples.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall with i_x_sample, i_y_sample. A transfer
// happens at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_heading_degrees (0..359), one
// result per input transfer, in order.
// Configuration: i_cfg_we, i_cfg_idx, i_cfg_data; write only while idle.
// Index 0..3 are the x/y calibration max/min, 4 the offset in tenths.
// Throughput: one transfer per cycle while i_stall is low; the CORDIC is
// fully pipelined with one register stage per iteration.
// Path from input transfer to o_valid: the second front stage, the queue
// write, one load stage, the CORDIC stages, three post stages.
// A four-entry queue decouples the front from the CORDIC pipeline.
// When i_stall is high the back pipeline holds; the queue then fills and
// o_stall rises once the queue and the second front stage are full.
// Reset (synchronous, i_rst_n low): pipelines empty, registers take their
// calibration defaults.
// ----------------------------------------------------------------------------
module compass_heading_from_magnetometer_top import chfm_pkg::*; #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [SAMPLE_W-1:0]  i_x_sample,
    input  logic signed [SAMPLE_W-1:0]  i_y_sample,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [HEADING_W-1:0]        o_heading_degrees,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [SAMPLE_W-1:0]         i_cfg_data
);

    logic signed [SAMPLE_W-1:0] r_x_max, r_x_min, r_y_max, r_y_min;
    logic signed [OFFSET_W-1:0] r_offset;
    logic                       push, full, pop, empty;
    t_work                      front_work, queue_work;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_max  <= 16'sd9952;
            r_x_min  <= -16'sd1437;
            r_y_max  <= 16'sd3737;
            r_y_min  <= -16'sd7930;
            r_offset <= -13'sd23;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_X_MAX:  r_x_max  <= i_cfg_data;
                REG_X_MIN:  r_x_min  <= i_cfg_data;
                REG_Y_MAX:  r_y_max  <= i_cfg_data;
                REG_Y_MIN:  r_y_min  <= i_cfg_data;
                REG_OFFSET: r_offset <= i_cfg_data[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // centre, scale and classify
    chfm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_x_sample (i_x_sample),
        .i_y_sample (i_y_sample),
        .i_x_max    (r_x_max),
        .i_x_min    (r_x_min),
        .i_y_max    (r_y_max),
        .i_y_min    (r_y_min),
        .i_full     (full),
        .o_push     (push),
        .o_work     (front_work)
    );

    chfm_fifo #(.DEPTH(4)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (front_work),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_work  (queue_work)
    );

    // arctangent and heading formatting
    chfm_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_empty           (empty),
        .i_work            (queue_work),
        .o_pop             (pop),
        .i_offset          (r_offset),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_heading_degrees (o_heading_degrees)
    );

endmodule

FILE: hdl/chfm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chfm_front
// Centres samples, forms the scaled vector and classifies its quadrant.
// ----------------------------------------------------------------------------
module chfm_front import chfm_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [SAMPLE_W-1:0] i_x_sample,
    input  logic signed [SAMPLE_W-1:0] i_y_sample,
    input  logic signed [SAMPLE_W-1:0] i_x_max,
    input  logic signed [SAMPLE_W-1:0] i_x_min,
    input  logic signed [SAMPLE_W-1:0] i_y_max,
    input  logic signed [SAMPLE_W-1:0] i_y_min,
    input  logic                       i_full,
    output logic                       o_push,
    output t_work                      o_work
);

    logic                       en;
    logic signed [CENTRE_W-1:0] n_cx, n_cy;
    logic signed [SPAN_W-1:0]   spx, spy, n_spx, n_spy;
    logic                       r_v1, r_v2;
    logic signed [CENTRE_W-1:0] r_cx, r_cy;
    logic signed [SPAN_W-1:0]   r_spx, r_spy;
    logic signed [PROD_W-1:0]   r_bx, r_by;

    assign en      = !r_v2 || !i_full;
    assign o_stall = !en;
    assign o_push  = r_v2 && !i_full;

    always_comb begin
        n_cx = (CENTRE_W'(i_x_sample) <<< 1) - (CENTRE_W'(i_x_max) + CENTRE_W'(i_x_min));
        n_cy = (CENTRE_W'(i_y_sample) <<< 1) - (CENTRE_W'(i_y_max) + CENTRE_W'(i_y_min));
        spx  = SPAN_W'(i_x_max) - SPAN_W'(i_x_min);
        spy  = SPAN_W'(i_y_max) - SPAN_W'(i_y_min);
        if (spx == '0) spx = SPAN_W'(1);
        if (spy == '0) spy = SPAN_W'(1);
        // opposite span signs: negate both products to keep the factor positive
        if (spx[SPAN_W-1] != spy[SPAN_W-1]) begin
            n_spx = -spx;
            n_spy = -spy;
        end else begin
            n_spx = spx;
            n_spy = spy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        if (en) begin
            r_cx  <= n_cx;
            r_cy  <= n_cy;
            r_spx <= n_spx;
            r_spy <= n_spy;
            r_bx  <= PROD_W'(r_cx) * PROD_W'(r_spy);
            r_by  <= PROD_W'(r_cy) * PROD_W'(r_spx);
        end
    end

    always_comb begin
        o_work.special = 1'b0;
        o_work.wx      = r_bx;
        o_work.wy      = r_by;
        o_work.base    = PHI_90;
        if (r_bx == '0) begin
            o_work.special = 1'b1;
            if (r_by > 0)      o_work.base = PHI_180;
            else if (r_by < 0) o_work.base = PHI_0;
            else               o_work.base = PHI_90;
        end else if (r_bx < 0) begin
            o_work.wx   = -r_bx;
            o_work.wy   = -r_by;
            o_work.base = PHI_270;
        end
    end

endmodule

FILE: hdl/chfm_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chfm_fifo
// Short queue of classified work between front and back.
// ----------------------------------------------------------------------------
module chfm_fifo import chfm_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_work,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_work o_work
);

    localparam int AW = $clog2(DEPTH);

    t_work         r_mem [0:DEPTH-1];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_work  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
        if (i_push) r_mem[r_wp] <= i_work;
    end

endmodule

FILE: hdl/chfm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chfm_back
// CORDIC arctangent pipeline, offset, truncation and wrap to whole degrees.
// ----------------------------------------------------------------------------
module chfm_back import chfm_pkg::*; #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    input  t_work                       i_work,
    output logic                        o_pop,
    input  logic signed [OFFSET_W-1:0]  i_offset,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [HEADING_W-1:0]        o_heading_degrees
);

    localparam int N = CORDIC_STAGES;

    logic                       en;
    logic signed [CORD_W-1:0]   r_x [0:N];
    logic signed [CORD_W-1:0]   r_y [0:N];
    logic signed [ANGLE_W-1:0]  r_z [0:N];
    logic                       r_sp [0:N];
    logic signed [PHI_W-1:0]    r_base [0:N];
    logic                       r_v [0:N];
    logic                       r_va, r_vb, r_ov;
    logic signed [PHI_W-1:0]    phi;
    logic signed [23:0]         r_p;
    logic [22:0]                absp;
    logic                       r_neg;
    logic [28:0]                r_prod;
    logic signed [11:0]         q, m;
    logic [HEADING_W-1:0]       r_hd;

    assign en                = !r_ov || !i_stall;
    assign o_pop             = en && !i_empty;
    assign o_valid           = r_ov;
    assign o_heading_degrees = r_hd;

    // load stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v[0] <= 1'b0;
        else if (en)  r_v[0] <= !i_empty;
        if (en) begin
            r_x[0]    <= CORD_W'(i_work.wx) <<< PRESHIFT;
            r_y[0]    <= CORD_W'(i_work.wy) <<< PRESHIFT;
            r_z[0]    <= '0;
            r_sp[0]   <= i_work.special;
            r_base[0] <= i_work.base;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[g+1] <= 1'b0;
            else if (en)  r_v[g+1] <= r_v[g];
            if (en) begin
                // rotate towards the x axis
                if (r_y[g] > 0) begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + atan_tab(g);
                end else begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - atan_tab(g);
                end
                r_sp[g+1]   <= r_sp[g];
                r_base[g+1] <= r_base[g];
            end
        end
    end

    assign phi  = r_base[N] + (r_sp[N] ? PHI_0 : PHI_W'(r_z[N]));
    assign absp = r_p[23] ? 23'(-r_p) : 23'(r_p);

    always_comb begin
        // truncate toward zero, then wrap by true modulo
        q = 12'(r_prod >> 18);
        if (r_neg) q = -q;
        m = q + 12'sd1080;
        if (m >= 12'sd1440) m = m - 12'sd1440;
        if (m >= 12'sd720)  m = m - 12'sd720;
        if (m >= 12'sd360)  m = m - 12'sd360;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_va <= r_v[N];
            r_vb <= r_va;
            r_ov <= r_vb;
        end
        if (en) begin
            r_p    <= 24'(phi) * 24'sd10 - (24'(i_offset) <<< ANG_FRAC);
            r_neg  <= r_p[23];
            // divide by 2560: shift by 512, then multiply by 1/5
            r_prod <= 29'(absp[22:9]) * 29'd52429;
            r_hd   <= HEADING_W'(m);
        end
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the hard-iron corrected compass heading block.
// ----------------------------------------------------------------------------
// Drives x/y samples over the valid/stall channel and predicts every heading
// with a bit-exact CORDIC model of its own. It walks a directed table first
// (calibration extremes, axis-aligned and zero-centred samples, offsets),
// then random samples under several calibrations, with random idling on
// both channels.
// ----------------------------------------------------------------------------
module testbench;
    import chfm_pkg::*;

    localparam int STAGES    = 16;
    localparam int WATCHDOG  = 20000;
    localparam int DRAIN_CYC = STAGES + 20;

    typedef struct {
        logic signed [SAMPLE_W-1:0] xs;
        logic signed [SAMPLE_W-1:0] ys;
        int                         want;   // -1: use the predictor
    } t_row;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] x_smp = '0;
    logic signed [SAMPLE_W-1:0] y_smp = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [HEADING_W-1:0]       heading;
    logic                       cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_idx = REG_X_MAX;
    logic [SAMPLE_W-1:0]        cfg_data = '0;

    // predictor copy of the calibration registers
    longint cal_xmax, cal_xmin, cal_ymax, cal_ymin, cal_offset;

    int heading_q[$];
    int fail_count = 0;
    int idle_cycles = 0;
    int send_gap_pct = 0;
    int recv_gap_pct = 0;

    compass_heading_from_magnetometer_top #(.CORDIC_STAGES(STAGES)) dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_valid           (in_valid),
        .o_stall           (in_stall),
        .i_x_sample        (x_smp),
        .i_y_sample        (y_smp),
        .o_valid           (out_valid),
        .i_stall           (out_stall),
        .o_heading_degrees (heading),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_data        (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint floor_shr(longint v, int s);
        if (v >= 0) return v >>> s;
        return -((-v - 1) >>> s) - 1;
    endfunction

    // vectoring CORDIC: atan(b/a) for a > 0, degrees with 8 fraction bits
    function automatic longint cordic_angle(longint a, longint b);
        longint z, ta, tb;
        z = 0;
        for (int i = 0; i < STAGES && i < MAX_STAGES; i++) begin
            ta = floor_shr(a, i);
            tb = floor_shr(b, i);
            if (b > 0) begin
                a = a + tb;
                b = b - ta;
                z = z + longint'(atan_tab(i));
            end else begin
                a = a - tb;
                b = b + ta;
                z = z - longint'(atan_tab(i));
            end
        end
        return z;
    endfunction

    function automatic int predict_heading(logic signed [SAMPLE_W-1:0] xs,
                                           logic signed [SAMPLE_W-1:0] ys);
        longint cx, cy, spx, spy, bx, by, phi, p, q, r;
        cx = 2 * longint'(xs) - (cal_xmax + cal_xmin);
        cy = 2 * longint'(ys) - (cal_ymax + cal_ymin);
        spx = cal_xmax - cal_xmin;
        spy = cal_ymax - cal_ymin;
        if (spx == 0) spx = 1;
        if (spy == 0) spy = 1;
        bx = cx * spy;
        by = cy * spx;
        if ((spx < 0) != (spy < 0)) begin
            bx = -bx;
            by = -by;
        end
        if (bx == 0) begin
            if (by > 0) phi = 180 * 256;
            else if (by < 0) phi = 0;
            else phi = 90 * 256;
        end else if (bx > 0) begin
            phi = 90 * 256 + cordic_angle(bx <<< PRESHIFT, by <<< PRESHIFT);
        end else begin
            phi = 270 * 256 + cordic_angle((-bx) <<< PRESHIFT, (-by) <<< PRESHIFT);
        end
        // SV division truncates toward zero, as wanted here
        p = phi * 10 - cal_offset * 256;
        q = p / 2560;
        r = q % 360;
        if (r < 0) r += 360;
        return int'(r);
    endfunction

    // write one register at a falling edge; the block must be idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= SAMPLE_W'(val);
        case (idx)
            REG_X_MAX:  cal_xmax = longint'($signed(SAMPLE_W'(val)));
            REG_X_MIN:  cal_xmin = longint'($signed(SAMPLE_W'(val)));
            REG_Y_MAX:  cal_ymax = longint'($signed(SAMPLE_W'(val)));
            REG_Y_MIN:  cal_ymin = longint'($signed(SAMPLE_W'(val)));
            REG_OFFSET: cal_offset = longint'($signed(OFFSET_W'(val)));
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic calibrate(longint xmax, longint xmin, longint ymax, longint ymin,
                             longint offs);
        write_reg(REG_X_MAX, xmax);
        write_reg(REG_X_MIN, xmin);
        write_reg(REG_Y_MAX, ymax);
        write_reg(REG_Y_MIN, ymin);
        write_reg(REG_OFFSET, offs);
    endtask

    // drop valid, wait for every heading to come back, then let the pipe empty
    task automatic drain;
        in_valid <= 1'b0;
        while (heading_q.size() != 0) @(negedge clk);
        repeat (DRAIN_CYC) @(negedge clk);
    endtask

    // offer one sample and hold it until the transfer happens
    task automatic send_sample(logic signed [SAMPLE_W-1:0] xs,
                               logic signed [SAMPLE_W-1:0] ys, int want);
        int h;
        while ($urandom_range(99, 0) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        x_smp    <= xs;
        y_smp    <= ys;
        h = predict_heading(xs, ys);
        if (want >= 0 && want != h)
            $display("%0t note: table row x=%0d y=%0d typed %0d, model %0d",
                     $time, xs, ys, want, h);
        heading_q.push_back(want >= 0 ? want : h);
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // output side: sample at the rising edge, stall changes at falling edge
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (heading_q.size() == 0) begin
                $display("%0t unexpected heading: expected none, actual %0d",
                         $time, heading);
                fail_count++;
            end else begin
                int exp_h;
                exp_h = heading_q.pop_front();
                if (int'(heading) != exp_h) begin
                    $display("%0t heading mismatch: expected %0d, actual %0d",
                             $time, exp_h, heading);
                    fail_count++;
                end
            end
        end
    end

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99, 0) < recv_gap_pct);
    end

    // watchdog: count cycles in which neither channel moves
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // random samples; mostly within the calibration window, some full range
    task automatic random_phase(int count);
        logic signed [SAMPLE_W-1:0] xs, ys;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(3, 0) != 0) begin
                xs = SAMPLE_W'(cal_xmin + ($urandom % (((cal_xmax - cal_xmin) < 0 ?
                     cal_xmin - cal_xmax : cal_xmax - cal_xmin) + 1)) *
                     ((cal_xmax >= cal_xmin) ? 1 : -1));
                ys = SAMPLE_W'(cal_ymin + ($urandom % (((cal_ymax - cal_ymin) < 0 ?
                     cal_ymin - cal_ymax : cal_ymax - cal_ymin) + 1)) *
                     ((cal_ymax >= cal_ymin) ? 1 : -1));
            end else begin
                xs = SAMPLE_W'($urandom);
                ys = SAMPLE_W'($urandom);
            end
            send_sample(xs, ys, -1);
        end
    endtask

    t_row dir_rows[$];

    initial begin
        cal_xmax = 9952; cal_xmin = -1437; cal_ymax = 3737; cal_ymin = -7930;
        cal_offset = -23;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table; typed results only where they follow at a glance
        // reset calibration centre: x 8515/2, y -4193/2; offset -2.3 deg
        dir_rows = '{
            '{16'sd4257, -16'sd2097, -1},
            '{16'sd4258, -16'sd2097, -1},
            '{-16'sd32768, -16'sd32768, -1},
            '{16'sd32767, 16'sd32767, -1},
            '{-16'sd32768, 16'sd32767, -1},
            '{16'sd32767, -16'sd32768, -1},
            '{16'sd9952, 16'sd3737, -1},
            '{-16'sd1437, -16'sd7930, -1},
            '{16'sd0, 16'sd0, -1},
            '{-16'sd1, 16'sd1, -1}
        };
        send_gap_pct = 0;
        recv_gap_pct = 0;
        foreach (dir_rows[k]) send_sample(dir_rows[k].xs, dir_rows[k].ys, dir_rows[k].want);
        drain();

        // centred calibration, no offset: samples on the y axis are exact,
        // those on the x axis go through the CORDIC and land just below
        calibrate(100, -100, 100, -100, 0);
        dir_rows = '{
            '{16'sd0, 16'sd0, 90},
            '{16'sd0, 16'sd50, 180},
            '{16'sd0, -16'sd50, 0},
            '{16'sd50, 16'sd0, -1},
            '{-16'sd50, 16'sd0, -1},
            '{16'sd50, 16'sd50, -1},
            '{-16'sd50, -16'sd50, -1},
            '{-16'sd50, 16'sd50, -1}
        };
        foreach (dir_rows[k]) send_sample(dir_rows[k].xs, dir_rows[k].ys, dir_rows[k].want);
        drain();

        // zero span on both axes, then reversed calibration, offset extremes
        calibrate(5, 5, -7, -7, 3600);
        send_sample(16'sd6, -16'sd8, -1);
        send_sample(16'sd5, -16'sd7, 90);
        drain();
        calibrate(-32768, 32767, 32767, -32768, -3600);
        send_sample(16'sd1000, -16'sd3000, -1);
        send_sample(-16'sd32768, 16'sd32767, -1);
        drain();
        // offset outside the nominal range: largest positive 13-bit value,
        // then the most negative one
        write_reg(REG_OFFSET, 4095);
        send_sample(16'sd123, 16'sd456, -1);
        drain();
        write_reg(REG_OFFSET, -4096);
        send_sample(-16'sd123, 16'sd456, -1);
        drain();

        // random phases: sender idles lightly, then receiver lightly, then none
        calibrate(9952, -1437, 3737, -7930, -23);
        send_gap_pct = 7;  recv_gap_pct = 52;
        random_phase(250);
        drain();
        calibrate(32767, -32768, 32767, -32768, 3600);
        random_phase(150);
        drain();
        send_gap_pct = 52; recv_gap_pct = 7;
        calibrate($urandom_range(65535, 0), $urandom_range(65535, 0),
                  $urandom_range(65535, 0), $urandom_range(65535, 0),
                  longint'($urandom_range(7200, 0)) - 3600);
        random_phase(300);
        drain();
        calibrate(-500, 400, 300, -900, -3600);
        random_phase(150);
        drain();
        send_gap_pct = 0;  recv_gap_pct = 0;
        calibrate(2000, -6000, -100, -100, 17);
        random_phase(200);
        drain();
        calibrate($urandom_range(65535, 0), $urandom_range(65535, 0),
                  $urandom_range(65535, 0), $urandom_range(65535, 0),
                  $urandom_range(8191, 0));
        random_phase(200);
        drain();

        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
